// ===== sv/pceil_pkg.sv =====
// Package for the posit32 ceiling unit: posit constants and stage payload types.
// No dependencies.
package pceil_pkg;
  localparam logic [31:0] NarPattern   = 32'h8000_0000;
  localparam logic [31:0] OnePattern   = 32'h4000_0000;
  localparam logic [31:0] TwoPattern   = 32'h4800_0000;
  localparam logic [31:0] ThreePattern = 32'h4C00_0000;
  localparam logic [31:0] IntBound     = 32'h7E80_0000;

  typedef enum logic [1:0] {
    PASS_IN,
    FIXED_RES,
    GENERAL_RES
  } res_kind_t;

  typedef struct packed {
    logic [31:0] orig;
    logic [31:0] mag;
    logic        neg;
    res_kind_t   kind;
    logic [31:0] fixed;
  } stage_t;
endpackage

// ===== sv/pceil_round.sv =====
// Rounding core of the posit32 ceiling unit: decodes the regime and exponent,
// clears the fraction and rounds up. Three register stages. Uses pceil_pkg.
module pceil_round import pceil_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic        vin,
  input  stage_t      din,
  output logic        v3,
  output logic [31:0] res3
);
  // Stage 1: sign, magnitude and classification.
  logic   v1_r;
  stage_t s1_r;
  // Stage 2: unit position of the integer LSB.
  logic   v2_r;
  stage_t s2_r;
  logic [31:0] unit2_r;
  logic   v3_r;
  logic [31:0] res3_r;

  logic [31:0] mag_c;
  logic        neg_c;
  stage_t      s1_nxt;
  logic [5:0]  run;
  logic [5:0]  scale;
  logic [31:0] probe;
  logic [31:0] unit_nxt;
  logic [31:0] kept;
  logic [31:0] r;

  always_comb begin
    neg_c = din.orig[31] && din.orig != NarPattern;
    mag_c = neg_c ? (32'd0 - din.orig) : din.orig;
    s1_nxt = din;
    s1_nxt.neg = neg_c;
    s1_nxt.mag = mag_c;
    s1_nxt.fixed = '0;
    if (din.orig == NarPattern || mag_c == 32'd0 || mag_c >= IntBound) begin
      s1_nxt.kind = PASS_IN;
    end else if (mag_c <= OnePattern) begin
      s1_nxt.kind = FIXED_RES;
      s1_nxt.fixed = (neg_c && mag_c != OnePattern) ? 32'd0 : OnePattern;
    end else if (mag_c <= TwoPattern) begin
      s1_nxt.kind = FIXED_RES;
      s1_nxt.fixed = (neg_c && mag_c != TwoPattern) ? OnePattern : TwoPattern;
    end else if (mag_c <= ThreePattern) begin
      s1_nxt.kind = FIXED_RES;
      s1_nxt.fixed = (neg_c && mag_c != ThreePattern) ? TwoPattern : ThreePattern;
    end else begin
      s1_nxt.kind = GENERAL_RES;
    end
  end

  // Regime run length of ones from bit 29 downward; the ones-run is a
  // leading-one count on a 30-bit field.
  always_comb begin
    run = 6'd30;
    for (int i = 29; i >= 0; i--) begin
      if (!s1_r.mag[i] && run == 6'd30) run = 6'(29 - i);
    end
    scale = 6'({run, 2'b00});
    probe = (run >= 6'd30) ? 32'd0 : (32'h2000_0000 >> run);
    probe = probe >> 1;
    if ((probe & s1_r.mag) != 32'd0) scale = scale + 6'd2;
    probe = probe >> 1;
    if ((probe & s1_r.mag) != 32'd0) scale = scale + 6'd1;
    unit_nxt = (scale >= 6'd32) ? 32'd0 : (probe >> scale);
  end

  // unit is the integer LSB position; everything below is fraction.
  always_comb begin
    kept = s2_r.mag & ~(unit2_r - 32'd1) | (unit2_r == 32'd0 ? s2_r.mag : 32'd0);
    r = kept;
    if (!s2_r.neg && kept != s2_r.mag) r = kept + unit2_r;
    if (s2_r.kind == PASS_IN) r = s2_r.orig;
    else begin
      if (s2_r.kind == FIXED_RES) r = s2_r.fixed;
      if (s2_r.neg) r = 32'd0 - r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= vin;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    if (adv) begin
      s1_r <= s1_nxt;
      s2_r <= s1_r;
      unit2_r <= unit_nxt;
      res3_r <= r;
    end
  end

  assign v3 = v3_r;
  assign res3 = res3_r;
endmodule

// ===== sv/posit32_ceil.sv =====
// posit32_ceil: ceiling of a 32-bit posit (es = 2), returned as a posit.
// One request per cycle while the output is not stalled.
// The three-stage rounding pipeline sets the latency; a stall holds all stages.
// Reset (synchronous, rst_n low) clears the stage valid bits only.
module posit32_ceil import pceil_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_posit_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_posit_out
);
  stage_t din;
  logic   adv;

  always_comb begin
    din = '0;
    din.orig = in_posit_in;
  end

  // The whole pipeline moves whenever the output slot is free to advance.
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;

  pceil_round u_round (
    .clk  (clk),
    .rst_n(rst_n),
    .adv  (adv),
    .vin  (in_valid),
    .din  (din),
    .v3   (out_valid),
    .res3 (out_posit_out)
  );
endmodule

// ===== bench/posit32_ceil_tb.sv =====
// Testbench for posit32_ceil: drives posit32 patterns with random gaps and stalls,
// predicts each ceiling and compares it with the block's result.
// Depends on pceil_pkg and the posit32_ceil RTL.
module posit32_ceil_tb;
  import pceil_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  class ceil_scoreboard;
    logic [31:0] pending_ceil[$];
    int errors;

    // Ceiling of the magnitude above three, below the integer bound.
    function logic [31:0] ceil_mag(logic [31:0] mag, bit neg);
      logic [31:0] probe, frac_mask, lost;
      int scale;
      probe = 32'h2000_0000;
      scale = 0;
      while (probe != 0 && (probe & mag) != 0) begin
        scale += 4;
        probe >>= 1;
      end
      probe >>= 1;
      if ((probe & mag) != 0) scale += 2;
      probe >>= 1;
      if ((probe & mag) != 0) scale += 1;
      probe = (scale >= 32) ? 32'h0 : (probe >> scale);
      probe >>= 1;
      frac_mask = probe | (probe - 32'h1);
      lost = mag & frac_mask;
      mag = mag & ~frac_mask;
      if (!neg && lost != 0) mag = mag + (probe << 1);
      return mag;
    endfunction

    function logic [31:0] ceil_of(logic [31:0] a);
      logic [31:0] mag, res;
      bit neg;
      if (a == NarPattern) return a;
      neg = a > NarPattern;
      mag = neg ? -a : a;
      if (mag == 0) return a;
      if (mag <= OnePattern) res = (neg && mag != OnePattern) ? 32'h0 : OnePattern;
      else if (mag <= TwoPattern) res = (neg && mag != TwoPattern) ? OnePattern : TwoPattern;
      else if (mag <= ThreePattern)
        res = (neg && mag != ThreePattern) ? TwoPattern : ThreePattern;
      else if (mag >= IntBound) return a;
      else res = ceil_mag(mag, neg);
      return neg ? -res : res;
    endfunction

    function void note_request(logic [31:0] a);
      pending_ceil.push_back(ceil_of(a));
    endfunction

    function void check_result(logic [31:0] got);
      logic [31:0] want;
      if (pending_ceil.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, got);
        errors++;
        return;
      end
      want = pending_ceil.pop_front();
      if (got !== want) begin
        $display("%0t: posit_out mismatch, expected %h, actual %h", $realtime, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, out_stall = 0;
  logic [31:0] in_posit_in = 0;
  logic in_stall, out_valid;
  logic [31:0] out_posit_out;
  ceil_scoreboard sb = new();
  bit rx_busy = 1;

  posit32_ceil u_dut (.*);

  initial forever #4 clk = ~clk;

  function int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Gap of idle cycles before the request, then hold until accepted.
  task send_request(logic [31:0] a, bit with_gaps);
    int g;
    g = with_gaps ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    in_posit_in <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function logic [31:0] random_posit();
    int r;
    logic [31:0] v;
    r = $urandom_range(0, 9);
    v = $urandom;
    case (r)
      0: v = $urandom_range(0, 32'h4C00_0000 + 8) ^ ($urandom_range(0, 1) << 31);
      1: v = -$urandom_range(32'h3FFF_FFF0, 32'h4C00_0010);
      2: v = $urandom_range(32'h7E7F_FF00, 32'h7EFF_FFFF) ^ ($urandom_range(0, 1) ? 32'hFFFF_FFFF : 0);
      default: ;
    endcase
    return v;
  endfunction

  // Receiver: random stalls, with stall-free stretches.
  initial begin
    int s;
    @(posedge clk iff rst_n);
    while (rx_busy) begin
      s = gap_len();
      out_stall <= (s > 0);
      repeat (s > 0 ? s : $urandom_range(1, 20)) @(posedge clk);
    end
    out_stall <= 0;
  end

  always @(posedge clk)
    if (rst_n && out_valid && !out_stall) sb.check_result(out_posit_out);

  initial begin
    logic [31:0] directed[$];
    int wait_cycles;
    directed = '{32'h0, NarPattern, 32'h0000_0001, 32'hFFFF_FFFF, 32'h3FFF_FFFF, OnePattern,
                 -OnePattern, -(OnePattern - 1), 32'h4000_0001, TwoPattern, -TwoPattern,
                 -(TwoPattern + 1), 32'h4800_0001, ThreePattern, -ThreePattern,
                 -(ThreePattern - 1), 32'h4C00_0001, IntBound - 1, IntBound, -IntBound,
                 -(IntBound - 1), 32'h7FFF_FFFF, 32'h8000_0001, 32'h5123_4567, 32'hAEDC_BA99};
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (directed[i]) begin
      send_request(directed[i], 0);
      sb.note_request(directed[i]);
    end
    repeat (1900) begin
      logic [31:0] a;
      a = random_posit();
      send_request(a, 1);
      sb.note_request(a);
    end
    in_valid <= 0;
    wait_cycles = 0;
    while (sb.pending_ceil.size() != 0 && wait_cycles < 10000) begin
      @(posedge clk);
      wait_cycles++;
    end
    rx_busy = 0;
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending_ceil.size() == 0)
      $display("posit32_ceil verification clean");
    else
      $display("posit32_ceil verification failed");
    $finish;
  end

  initial begin
    #2ms;
    $display("posit32_ceil verification failed");
    $finish;
  end
endmodule
